>>> hdl/mfbp_pkg.sv
// Package for the MSB-first bit packer: sizes, mode codes and the job record
// passed from the front end through the queue to the word emitter.
// No dependencies.
package mfbp_pkg;

  localparam int WORD_BITS     = 16;
  localparam int MAX_CODE_BITS = 32;
  localparam int CODE_W        = 32;
  localparam int CODE_LEN_W    = $clog2(MAX_CODE_BITS + 1);
  localparam int MODE_W        = 2;

  // Words one append can complete, and the window that holds pending bits,
  // the new code and the leftover bits after the last full word.
  localparam int MAX_WORDS = (WORD_BITS - 1 + MAX_CODE_BITS) / WORD_BITS;
  localparam int WIN_W     = WORD_BITS * (MAX_WORDS + 1);
  localparam int FILL_W    = $clog2(WORD_BITS);
  localparam int TOTAL_W   = $clog2(WORD_BITS + MAX_CODE_BITS);
  localparam int SHIFT_W   = $clog2(WIN_W + 1);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int SEL_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_FLUSH  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [MAX_WORDS-1:0][WORD_BITS-1:0] words;
    logic [CNT_W-1:0]                    count;
    logic                                padded;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/mfbp_if.sv
// Valid/ready channel interfaces of the bit packer: the item input and the
// packed word output. Depends on mfbp_pkg for the field widths.
interface mfbp_in_if;
  logic                                valid;
  logic                                ready;
  logic [mfbp_pkg::MODE_W-1:0]         mode;
  logic [mfbp_pkg::CODE_W-1:0]         code_value;
  logic [mfbp_pkg::CODE_LEN_W-1:0]     code_length;

  modport source (output valid, output mode, output code_value, output code_length,
                  input ready);
  modport sink   (input valid, input mode, input code_value, input code_length,
                  output ready);
endinterface

interface mfbp_out_if;
  logic                                valid;
  logic                                ready;
  logic [mfbp_pkg::WORD_BITS-1:0]      packed_word;
  logic                                is_padded;
  logic                                last;

  modport source (output valid, output packed_word, output is_padded, output last,
                  input ready);
  modport sink   (input valid, input packed_word, input is_padded, input last,
                  output ready);
endinterface

>>> hdl/mfbp_front.sv
// Front end of the bit packer: takes items, keeps the pending word and fill
// count, and merges each code in one funnel shift. Depends on mfbp_pkg, mfbp_if.
module mfbp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mfbp_in_if.sink              in_i,
  input  mfbp_pkg::q_status_t  q_stat_i,
  output logic                 push_o,
  output mfbp_pkg::job_t       job_o
);

  logic [mfbp_pkg::WORD_BITS-1:0]  pend_q, pend_d;
  logic [mfbp_pkg::FILL_W-1:0]     fill_q, fill_d;

  logic                            accept;
  logic                            push;
  logic [mfbp_pkg::CODE_LEN_W-1:0] len_sat;
  logic [mfbp_pkg::WIN_W-1:0]      mask;
  logic [mfbp_pkg::WIN_W-1:0]      code_ext;
  logic [mfbp_pkg::SHIFT_W-1:0]    sh;
  logic [mfbp_pkg::WIN_W-1:0]      win;
  logic [mfbp_pkg::TOTAL_W-1:0]    total;
  logic [mfbp_pkg::CNT_W-1:0]      nwords;
  logic [mfbp_pkg::TOTAL_W-1:0]    fill_new;
  logic [mfbp_pkg::WORD_BITS-1:0]  rem;
  mfbp_pkg::job_t                  job;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (in_i.code_length > mfbp_pkg::CODE_LEN_W'(mfbp_pkg::MAX_CODE_BITS)) begin
      len_sat = mfbp_pkg::CODE_LEN_W'(mfbp_pkg::MAX_CODE_BITS);
    end else begin
      len_sat = in_i.code_length;
    end

    mask     = ~({mfbp_pkg::WIN_W{1'b1}} << len_sat);
    code_ext = mfbp_pkg::WIN_W'(in_i.code_value) & mask;

    // Pending bits sit at the top of the window; the code lands right below
    // them. Bits under the pending ones are always zero.
    sh  = mfbp_pkg::SHIFT_W'(mfbp_pkg::WIN_W) - mfbp_pkg::SHIFT_W'(fill_q)
        - mfbp_pkg::SHIFT_W'(len_sat);
    win = {pend_q, {(mfbp_pkg::WIN_W - mfbp_pkg::WORD_BITS){1'b0}}} | (code_ext << sh);

    total    = mfbp_pkg::TOTAL_W'(fill_q) + mfbp_pkg::TOTAL_W'(len_sat);
    nwords   = '0;
    fill_new = total;
    rem      = win[mfbp_pkg::WIN_W-1 -: mfbp_pkg::WORD_BITS];
    for (int k = 1; k <= mfbp_pkg::MAX_WORDS; k++) begin
      if (total >= mfbp_pkg::TOTAL_W'(k * mfbp_pkg::WORD_BITS)) begin
        nwords   = mfbp_pkg::CNT_W'(k);
        fill_new = total - mfbp_pkg::TOTAL_W'(k * mfbp_pkg::WORD_BITS);
        rem      = win[mfbp_pkg::WIN_W-1-k*mfbp_pkg::WORD_BITS -: mfbp_pkg::WORD_BITS];
      end
    end

    job    = '0;
    push   = 1'b0;
    pend_d = pend_q;
    fill_d = fill_q;
    case (in_i.mode)
      mfbp_pkg::MODE_APPEND: begin
        for (int k = 0; k < mfbp_pkg::MAX_WORDS; k++) begin
          job.words[k] = win[mfbp_pkg::WIN_W-1-k*mfbp_pkg::WORD_BITS -: mfbp_pkg::WORD_BITS];
        end
        job.count  = nwords;
        job.padded = 1'b0;
        push       = (nwords != '0);
        pend_d     = rem;
        fill_d     = mfbp_pkg::FILL_W'(fill_new);
      end
      mfbp_pkg::MODE_FLUSH: begin
        job.words[0] = pend_q;
        job.count    = mfbp_pkg::CNT_W'(1);
        job.padded   = 1'b1;
        push         = (fill_q != '0);
        pend_d       = '0;
        fill_d       = '0;
      end
      mfbp_pkg::MODE_CLEAR: begin
        pend_d = '0;
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign push_o = accept && push;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> hdl/mfbp_queue.sv
// Short job queue between the packer front end and the word emitter.
// Depends on mfbp_pkg.
module mfbp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mfbp_pkg::job_t       job_i,
  input  logic                 pop_i,
  output mfbp_pkg::job_t       job_o,
  output mfbp_pkg::q_status_t  stat_o
);

  mfbp_pkg::job_t              mem_q [mfbp_pkg::QDEPTH];
  logic [mfbp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mfbp_pkg::QCNT_W-1:0] cnt_q;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == mfbp_pkg::QCNT_W'(mfbp_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_ptr_q];

  function automatic logic [mfbp_pkg::QPTR_W-1:0] next_ptr(
    input logic [mfbp_pkg::QPTR_W-1:0] p
  );
    if (p == mfbp_pkg::QPTR_W'(mfbp_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + mfbp_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + mfbp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - mfbp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/mfbp_back.sv
// Word emitter of the bit packer: walks the words of the queue head job into
// the registered output channel. Depends on mfbp_pkg, mfbp_if.
module mfbp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfbp_pkg::job_t       job_i,
  input  mfbp_pkg::q_status_t  q_stat_i,
  output logic                 pop_o,
  mfbp_out_if.source           out_o
);

  logic                           out_valid_q;
  logic [mfbp_pkg::WORD_BITS-1:0] word_q;
  logic                           padded_q;
  logic                           last_q;
  logic [mfbp_pkg::SEL_W-1:0]     sel_q;

  logic                           load;
  logic                           take;
  logic                           is_last;

  assign load    = !out_valid_q || out_o.ready;
  assign take    = load && !q_stat_i.empty;
  assign is_last = (mfbp_pkg::CNT_W'(sel_q) + mfbp_pkg::CNT_W'(1) == job_i.count);
  assign pop_o   = take && is_last;

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_word = word_q;
  assign out_o.is_padded   = padded_q;
  assign out_o.last        = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= '0;
    end else if (take) begin
      out_valid_q <= 1'b1;
      sel_q       <= is_last ? '0 : sel_q + mfbp_pkg::SEL_W'(1);
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q   <= job_i.words[sel_q];
      padded_q <= job_i.padded;
      last_q   <= is_last;
    end
  end

endmodule

>>> hdl/msb_first_bit_packer_16_unit.sv
// MSB-first bit packer with 16-bit output words, top level.
// Depends on mfbp_pkg, mfbp_if, mfbp_front, mfbp_queue, mfbp_back.
//
// Usage:
//   in_i carries items: mode (append, flush, clear), code_value and
//   code_length. An append packs the low code_length bits (at most 32)
//   below the pending bits, earliest bit first; every completed word goes
//   out on out_o with last set on the final word of the item. A flush sends
//   the pending bits zero padded (is_padded = 1) if any are pending, then
//   empties the accumulator. A clear drops pending bits silently.
//   Timing: a completed word is registered in the job queue and then in the
//   output register before it is valid on out_o. Items are taken one per
//   cycle while the queue is not full; the output moves one word per cycle
//   while the receiver is ready, so an append completing two words holds the
//   emitter until both have loaded. A two-entry job queue sits between the
//   packing front end and the emitter, so the front end keeps taking items
//   while the receiver stalls until the queue fills, then drops ready.
//   Reset (rst_ni low, asynchronous) empties the accumulator, the queue and
//   the output register.
module msb_first_bit_packer_16_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfbp_in_if.sink     in_i,
  mfbp_out_if.source  out_o
);

  logic                push;
  logic                pop;
  mfbp_pkg::job_t      job_in;
  mfbp_pkg::job_t      job_head;
  mfbp_pkg::q_status_t q_stat;

  mfbp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job_in)
  );

  mfbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .stat_o (q_stat)
  );

  mfbp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (job_head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

>>> hdl/mfbp_checker.sv
// Port-level checks of the bit packer output channel, and the bind that
// attaches them to the top level. Depends on mfbp_pkg.
module mfbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mfbp_pkg::WORD_BITS-1:0] packed_word_i,
  input logic                           is_padded_i,
  input logic                           last_i
);

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(packed_word_i) && $stable(is_padded_i) && $stable(last_i))
    else $error("output payload changed while stalled");

  // A flush makes at most one word, so a padded word ends its item.
  a_padded_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_padded_i |-> last_i)
    else $error("padded word without last");

  // A padded word never holds a full word of bits, so its lowest bit is padding.
  a_padded_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_padded_i |-> !packed_word_i[0])
    else $error("padded word has a set padding bit");

endmodule

bind msb_first_bit_packer_16_unit mfbp_checker u_mfbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .packed_word_i (out_o.packed_word),
  .is_padded_i   (out_o.is_padded),
  .last_i        (out_o.last)
);

>>> bench/testbench.sv
// Self-checking bench for msb_first_bit_packer_16_unit: a directed and random item stream
// goes in, and a bit-level packing predictor checks every word that comes out.
// Depends on mfbp_pkg, mfbp_if and the packer RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic [mfbp_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam int                          RANDOM_ITEMS = 1200;
  localparam int                          QUIET_LIMIT  = 1000;
  localparam int                          DRAIN_CYCLES = 8;

  typedef struct {
    logic [mfbp_pkg::MODE_W-1:0]     mode;
    logic [mfbp_pkg::CODE_W-1:0]     code;
    logic [mfbp_pkg::CODE_LEN_W-1:0] len;
  } code_item_t;

  typedef struct {
    logic [mfbp_pkg::WORD_BITS-1:0] word;
    logic                           padded;
    logic                           last;
  } packed_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  mfbp_in_if  in_ch ();
  mfbp_out_if out_ch ();

  msb_first_bit_packer_16_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  code_item_t     pending_items[$];
  packed_result_t expected_words[$];

  // Predictor state: bits collected so far, earliest bit at the top.
  logic [mfbp_pkg::WORD_BITS-1:0] acc_word;
  int                             acc_fill;

  int unsigned items_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Both sides run without gaps for a stretch in the middle of the random part.
  function automatic bit take_break();
    if (items_taken >= 400 && items_taken < 700) return 1'b0;
    return $urandom_range(99) < 25;
  endfunction

  task automatic pack_item(input code_item_t it);
    packed_result_t words_out[$];
    packed_result_t res;
    int             nbits;
    begin
      if (it.mode == mfbp_pkg::MODE_APPEND) begin
        nbits = (it.len > mfbp_pkg::MAX_CODE_BITS) ? mfbp_pkg::MAX_CODE_BITS : int'(it.len);
        for (int i = nbits - 1; i >= 0; i--) begin
          acc_word[mfbp_pkg::WORD_BITS-1-acc_fill] = it.code[i];
          acc_fill++;
          if (acc_fill == mfbp_pkg::WORD_BITS) begin
            res.word   = acc_word;
            res.padded = 1'b0;
            res.last   = 1'b0;
            words_out.push_back(res);
            acc_word = '0;
            acc_fill = 0;
          end
        end
      end else if (it.mode == mfbp_pkg::MODE_FLUSH) begin
        if (acc_fill != 0) begin
          res.word   = acc_word;
          res.padded = 1'b1;
          res.last   = 1'b0;
          words_out.push_back(res);
        end
        acc_word = '0;
        acc_fill = 0;
      end else if (it.mode == mfbp_pkg::MODE_CLEAR) begin
        acc_word = '0;
        acc_fill = 0;
      end
      if (words_out.size() != 0) words_out[$].last = 1'b1;
      foreach (words_out[k]) expected_words.push_back(words_out[k]);
    end
  endtask

  // Sender: an offered item stays on the bus until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= mfbp_pkg::MODE_APPEND;
      in_ch.code_value  <= '0;
      in_ch.code_length <= '0;
      items_taken       <= 0;
      acc_word          = '0;
      acc_fill          = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pack_item(pending_items.pop_front());
        items_taken <= items_taken + 1;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Held item, nothing changes.
      end else if (pending_items.size() != 0 && !take_break()) begin
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= pending_items[0].mode;
        in_ch.code_value  <= pending_items[0].code;
        in_ch.code_length <= pending_items[0].len;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: each word transfer is checked against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : word_check
    packed_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      mismatches   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected word: expected none, got word=%h padded=%b last=%b",
                   $time, out_ch.packed_word, out_ch.is_padded, out_ch.last);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.packed_word !== want.word || out_ch.is_padded !== want.padded ||
              out_ch.last !== want.last) begin
            mismatches <= mismatches + 1;
            $display("%0t: mismatch: expected word=%h padded=%b last=%b,",
                     $time, want.word, want.padded, want.last);
            $display("%0t:           got word=%h padded=%b last=%b",
                     $time, out_ch.packed_word, out_ch.is_padded, out_ch.last);
          end
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic code_item_t make_item(logic [mfbp_pkg::MODE_W-1:0] m,
                                           logic [mfbp_pkg::CODE_W-1:0] c,
                                           logic [mfbp_pkg::CODE_LEN_W-1:0] l);
    code_item_t it;
    it.mode = m;
    it.code = c;
    it.len  = l;
    return it;
  endfunction

  function automatic code_item_t random_item();
    code_item_t  it;
    int unsigned pick;
    pick    = $urandom_range(99);
    it.code = $urandom;
    if (pick < 84)      it.mode = mfbp_pkg::MODE_APPEND;
    else if (pick < 92) it.mode = mfbp_pkg::MODE_FLUSH;
    else if (pick < 97) it.mode = mfbp_pkg::MODE_CLEAR;
    else                it.mode = MODE_UNUSED;
    pick = $urandom_range(99);
    if (pick < 55)      it.len = mfbp_pkg::CODE_LEN_W'($urandom_range(1, 32));
    else if (pick < 75) it.len = mfbp_pkg::CODE_LEN_W'($urandom_range(1, 8));
    else if (pick < 85) it.len = mfbp_pkg::CODE_LEN_W'(mfbp_pkg::MAX_CODE_BITS);
    else if (pick < 92) it.len = '0;
    else                it.len = mfbp_pkg::CODE_LEN_W'($urandom_range(33, 63));
    return it;
  endfunction

  initial begin
    int counted;
    code_item_t it;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty appends and flushes, full-width codes, saturated
    // lengths, exact word boundaries, clears and the unused mode.
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hFFFF_FFFF, 6'd0));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hFFFF_FFFF, 6'd32));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0000_0000, 6'd32));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0000_0001, 6'd1));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hA5A5_A5A5, 6'd63));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'hFFFF_FFFF, 6'd63));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hFFFF_7FFF, 6'd15));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hFFFF_FFFE, 6'd1));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h1234_ABCD, 6'd16));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'hDEAD_BEEF, 6'd33));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0000_001B, 6'd5));
    pending_items.push_back(make_item(mfbp_pkg::MODE_CLEAR,  32'hFFFF_FFFF, 6'd32));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0));
    pending_items.push_back(make_item(MODE_UNUSED,           32'hFFFF_FFFF, 6'd63));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0000_0055, 6'd7));
    pending_items.push_back(make_item(MODE_UNUSED,           32'h1357_9BDF, 6'd20));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h8000_0001, 6'd31));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0001_FFFF, 6'd17));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h0000_0000, 6'd63));
    pending_items.push_back(make_item(mfbp_pkg::MODE_APPEND, 32'h7FFF_FFFF, 6'd32));
    pending_items.push_back(make_item(mfbp_pkg::MODE_FLUSH,  32'h0000_0000, 6'd0));

    // The sender holds off until every predicted word has come out.
    while (pending_items.size() != 0 || expected_words.size() != 0) @(negedge clk_i);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      it = random_item();
      pending_items.push_back(it);
      if (it.mode != MODE_UNUSED) counted++;
    end

    while (pending_items.size() != 0 || expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/mfbp_pkg.sv
hdl/mfbp_if.sv
hdl/mfbp_front.sv
hdl/mfbp_queue.sv
hdl/mfbp_back.sv
hdl/msb_first_bit_packer_16_unit.sv
hdl/mfbp_checker.sv
bench/testbench.sv
